@@ hdl/fcgi_pkg.sv @@
package fcgi_pkg;

    localparam int KEY_LEN = 16;

    localparam logic [7:0] REC_STDOUT = 8'd6;
    localparam logic [7:0] REC_STDERR = 8'd7;

    localparam logic [2:0] HDR_TYPE   = 3'd1;
    localparam logic [2:0] HDR_LEN_HI = 3'd4;
    localparam logic [2:0] HDR_LEN_LO = 3'd5;
    localparam logic [2:0] HDR_PAD    = 3'd6;
    localparam logic [2:0] HDR_LAST   = 3'd7;

    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_BIG_C = 8'h43;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_CONTENT = 3'b010,
        PH_PADDING = 3'b100
    } phase_t;

    typedef enum logic [3:0] {
        SC_KEY   = 4'b0001,
        SC_VALUE = 4'b0010,
        SC_BODY  = 4'b0100,
        SC_DONE  = 4'b1000
    } scan_phase_t;

    typedef enum logic [2:0] {
        NUM_BLANKS = 3'b001,
        NUM_DIGITS = 3'b010,
        NUM_ENDED  = 3'b100
    } num_stage_t;

    // per-byte control from the record framer to the body scanner
    typedef struct packed {
        logic        restart;
        logic        scan;
        logic [15:0] left;
    } scan_ctl_t;

    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h43; // C
            4'd1:    ch = 8'h6f; // o
            4'd2:    ch = 8'h6e; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6e; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2d; // -
            4'd8:    ch = 8'h4c; // L
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6e; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            4'd14:   ch = 8'h3a; // :
            default: ch = 8'h20; // space
        endcase
        return ch;
    endfunction

endpackage

@@ hdl/fastcgi_response_body_extractor_unit.sv @@
// FastCGI response body extractor
// in channel: one byte of the record stream per item (in_valid, in_stall,
// in_byte). out channel: one extracted body byte per item (out_valid,
// out_stall, body_byte, body_last), body_last set on the final byte.
// an item is taken on a rising edge with valid high and stall low.
// record headers, padding and content of other record types give no item;
// in stdout/stderr content the value after the first "Content-Length: "
// selects how many trailing content bytes after the blank line are passed.
// an accepted byte is held in the input register, then framed and scanned
// from there; a resulting body byte is loaded into the result register that
// drives the outputs. throughput: one byte every cycle while the receiver
// does not stall, with the single input register feeding the result register.
// when the receiver stalls, the result register holds its item and the
// input register keeps one byte; in_stall rises only while both are full.
// reset (rst_n low, asynchronous) empties both registers and returns the
// framer to the start of a record header with the scanner seeking the key.
module fastcgi_response_body_extractor_unit
    import fcgi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] body_byte,
    output logic       body_last
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic [7:0] body_byte_reg;
    logic       body_last_reg;
    logic       advance;
    logic       proc;
    logic       emit;
    logic       emit_last;
    scan_ctl_t  ctl;

    assign advance  = !out_valid_reg || !out_stall;
    assign proc     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    fcgi_frame u_frame (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (proc),
        .data  (in_byte_reg),
        .ctl   (ctl)
    );

    fcgi_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (proc),
        .data      (in_byte_reg),
        .ctl       (ctl),
        .emit      (emit),
        .emit_last (emit_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= proc && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= in_byte;
        if (proc && emit)
        begin
            body_byte_reg <= in_byte_reg;
            body_last_reg <= emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign body_byte = body_byte_reg;
    assign body_last = body_last_reg;

endmodule

@@ hdl/fcgi_frame.sv @@
module fcgi_frame
    import fcgi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] data,
    output scan_ctl_t  ctl
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  header_index_reg, header_index_next;
    logic [7:0]  record_type_reg, record_type_next;
    logic [15:0] content_left_reg, content_left_next;
    logic [7:0]  padding_left_reg, padding_left_next;
    logic        is_output_rec;

    assign is_output_rec = (record_type_reg == REC_STDOUT) || (record_type_reg == REC_STDERR);

    always_comb
    begin
        phase_next        = phase_reg;
        header_index_next = header_index_reg;
        record_type_next  = record_type_reg;
        content_left_next = content_left_reg;
        padding_left_next = padding_left_reg;
        ctl               = '0;
        unique case (phase_reg)
            PH_CONTENT:
            begin
                if (content_left_reg != 16'd0)
                begin
                    content_left_next = content_left_reg - 16'd1;
                    ctl.scan          = is_output_rec;
                end
                if (content_left_next == 16'd0)
                    phase_next = (padding_left_reg != 8'd0) ? PH_PADDING : PH_HEADER;
            end
            PH_PADDING:
            begin
                if (padding_left_reg != 8'd0)
                    padding_left_next = padding_left_reg - 8'd1;
                if (padding_left_next == 8'd0)
                    phase_next = PH_HEADER;
            end
            default:
            begin
                phase_next = PH_HEADER;
                unique case (header_index_reg)
                    HDR_TYPE:   record_type_next = data;
                    HDR_LEN_HI: content_left_next = {data, content_left_reg[7:0]};
                    HDR_LEN_LO: content_left_next = {content_left_reg[15:8], data};
                    HDR_PAD:    padding_left_next = data;
                    default:    ;
                endcase
                if (header_index_reg == HDR_LAST)
                begin
                    header_index_next = 3'd0;
                    ctl.restart       = 1'b1;
                    if (content_left_reg != 16'd0)
                        phase_next = PH_CONTENT;
                    else if (padding_left_reg != 8'd0)
                        phase_next = PH_PADDING;
                    else
                        phase_next = PH_HEADER;
                end
                else
                begin
                    header_index_next = header_index_reg + 3'd1;
                end
            end
        endcase
        ctl.left = content_left_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            header_index_reg <= 3'd0;
            record_type_reg  <= 8'd0;
            content_left_reg <= 16'd0;
            padding_left_reg <= 8'd0;
        end
        else if (en)
        begin
            phase_reg        <= phase_next;
            header_index_reg <= header_index_next;
            record_type_reg  <= record_type_next;
            content_left_reg <= content_left_next;
            padding_left_reg <= padding_left_next;
        end
    end

endmodule

@@ hdl/fcgi_scan.sv @@
module fcgi_scan
    import fcgi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] data,
    input  scan_ctl_t  ctl,
    output logic       emit,
    output logic       emit_last
);

    scan_phase_t scan_phase_reg, scan_phase_next;
    logic [4:0]  key_match_reg, key_match_next;
    logic [15:0] length_value_reg, length_value_next;
    logic [2:0]  blank_line_match_reg, blank_line_match_next;
    logic [15:0] skip_left_reg, skip_left_next;
    logic [15:0] emit_left_reg, emit_left_next;
    num_stage_t  num_stage_reg, num_stage_next;
    logic        num_neg_reg, num_neg_next;

    logic        is_digit;
    logic        is_blank;
    logic [19:0] num_prod;
    logic [7:0]  blank_char;
    logic [15:0] want;

    assign is_digit   = (data >= CH_ZERO) && (data <= CH_NINE);
    assign is_blank   = (data == CH_SPACE) || ((data >= CH_TAB) && (data <= CH_CR));
    assign num_prod   = {4'd0, length_value_reg} * 20'd10 + {16'd0, data[3:0]};
    assign blank_char = blank_line_match_reg[0] ? CH_LF : CH_CR;

    always_comb
    begin
        scan_phase_next       = scan_phase_reg;
        key_match_next        = key_match_reg;
        length_value_next     = length_value_reg;
        blank_line_match_next = blank_line_match_reg;
        skip_left_next        = skip_left_reg;
        emit_left_next        = emit_left_reg;
        num_stage_next        = num_stage_reg;
        num_neg_next          = num_neg_reg;
        emit                  = 1'b0;
        emit_last             = 1'b0;
        want                  = 16'd0;
        if (ctl.restart)
        begin
            scan_phase_next       = SC_KEY;
            key_match_next        = 5'd0;
            length_value_next     = 16'd0;
            blank_line_match_next = 3'd0;
            skip_left_next        = 16'd0;
            emit_left_next        = 16'd0;
            num_stage_next        = NUM_BLANKS;
            num_neg_next          = 1'b0;
        end
        else if (ctl.scan)
        begin
            unique case (scan_phase_reg)
                SC_KEY:
                begin
                    if (data == key_char(key_match_reg[3:0]))
                        key_match_next = key_match_reg + 5'd1;
                    else
                        key_match_next = (data == CH_BIG_C) ? 5'd1 : 5'd0;
                    if (key_match_next >= 5'(KEY_LEN))
                        scan_phase_next = SC_VALUE;
                end
                SC_VALUE:
                begin
                    // decimal reader in the manner of a string-to-int conversion
                    if (num_stage_reg != NUM_ENDED)
                    begin
                        if (is_digit)
                        begin
                            length_value_next = (num_prod > 20'd65535) ? 16'hffff
                                                                       : num_prod[15:0];
                            num_stage_next    = NUM_DIGITS;
                        end
                        else if (num_stage_reg == NUM_BLANKS && is_blank)
                        begin
                            num_stage_next = NUM_BLANKS;
                        end
                        else if (num_stage_reg == NUM_BLANKS
                                 && (data == CH_PLUS || data == CH_MINUS))
                        begin
                            num_neg_next   = (data == CH_MINUS);
                            num_stage_next = NUM_DIGITS;
                        end
                        else
                        begin
                            num_stage_next = NUM_ENDED;
                        end
                    end
                    if (data == blank_char)
                        blank_line_match_next = blank_line_match_reg + 3'd1;
                    else
                        blank_line_match_next = (data == CH_CR) ? 3'd1 : 3'd0;
                    if (blank_line_match_next >= 3'd4)
                    begin
                        want = (num_neg_next || num_stage_next == NUM_BLANKS)
                               ? 16'd0 : length_value_next;
                        if (want != 16'd0 && want <= ctl.left)
                        begin
                            skip_left_next  = ctl.left - want;
                            emit_left_next  = want;
                            scan_phase_next = SC_BODY;
                        end
                        else
                        begin
                            scan_phase_next = SC_DONE;
                        end
                    end
                end
                SC_BODY:
                begin
                    if (skip_left_reg != 16'd0)
                    begin
                        skip_left_next = skip_left_reg - 16'd1;
                    end
                    else if (emit_left_reg == 16'd0)
                    begin
                        scan_phase_next = SC_DONE;
                    end
                    else
                    begin
                        emit           = 1'b1;
                        emit_last      = (emit_left_reg == 16'd1);
                        emit_left_next = emit_left_reg - 16'd1;
                        if (emit_left_reg == 16'd1)
                            scan_phase_next = SC_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_phase_reg       <= SC_KEY;
            key_match_reg        <= 5'd0;
            length_value_reg     <= 16'd0;
            blank_line_match_reg <= 3'd0;
            skip_left_reg        <= 16'd0;
            emit_left_reg        <= 16'd0;
            num_stage_reg        <= NUM_BLANKS;
            num_neg_reg          <= 1'b0;
        end
        else if (en)
        begin
            scan_phase_reg       <= scan_phase_next;
            key_match_reg        <= key_match_next;
            length_value_reg     <= length_value_next;
            blank_line_match_reg <= blank_line_match_next;
            skip_left_reg        <= skip_left_next;
            emit_left_reg        <= emit_left_next;
            num_stage_reg        <= num_stage_next;
            num_neg_reg          <= num_neg_next;
        end
    end

endmodule

@@ tb/fastcgi_response_body_extractor_unit_test.sv @@
module fastcgi_response_body_extractor_unit_test;
    import fcgi_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TOTAL_BYTES = 1850;
    localparam logic [127:0] LENGTH_KEY = "Content-Length: ";

    typedef struct {
        logic [7:0] data;
        bit         hold;
    } stim_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } body_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] body_byte;
    logic       body_last;

    stim_item_t stim_q[$];
    body_beat_t body_expect_q[$];
    logic [7:0] content_buf[$];
    int         bytes_queued = 0;
    int         cycle_count = 0;
    int         fail_count = 0;
    int         gap_left = 0;
    int         stall_left = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;

    // predicted deframer state
    phase_t      rec_phase;
    logic [2:0]  hdr_idx;
    logic [7:0]  rec_type;
    logic [15:0] content_left;
    logic [7:0]  pad_left;
    scan_phase_t scan_st;
    logic [4:0]  key_hits;
    logic [15:0] len_value;
    logic [2:0]  crlf_hits;
    logic [15:0] skip_left;
    logic [15:0] emit_left;
    num_stage_t  num_st;
    bit          num_neg;

    fastcgi_response_body_extractor_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .body_byte (body_byte),
        .body_last (body_last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int idle_draw(input bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic clear_scan();
        scan_st   = SC_KEY;
        key_hits  = 5'd0;
        len_value = 16'd0;
        crlf_hits = 3'd0;
        skip_left = 16'd0;
        emit_left = 16'd0;
        num_st    = NUM_BLANKS;
        num_neg   = 1'b0;
    endtask

    task automatic scan_content_byte(input logic [7:0] c);
        logic [19:0] acc;
        logic [15:0] want;
        body_beat_t  beat;
        case (scan_st)
            SC_KEY:
            begin
                if (c == LENGTH_KEY[8 * (15 - key_hits[3:0]) +: 8])
                    key_hits = key_hits + 5'd1;
                else
                    key_hits = (c == CH_BIG_C) ? 5'd1 : 5'd0;
                if (key_hits >= 5'(KEY_LEN))
                    scan_st = SC_VALUE;
            end
            SC_VALUE:
            begin
                if (num_st != NUM_ENDED)
                begin
                    if (c >= CH_ZERO && c <= CH_NINE)
                    begin
                        acc = 20'(len_value) * 20'd10 + 20'(c - CH_ZERO);
                        len_value = (acc > 20'd65535) ? 16'hffff : acc[15:0];
                        num_st = NUM_DIGITS;
                    end
                    else if (num_st == NUM_BLANKS
                             && (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
                        num_st = NUM_BLANKS;
                    else if (num_st == NUM_BLANKS && (c == CH_PLUS || c == CH_MINUS))
                    begin
                        num_neg = (c == CH_MINUS);
                        num_st = NUM_DIGITS;
                    end
                    else
                        num_st = NUM_ENDED;
                end
                // blank line is cr lf cr lf
                if (c == (crlf_hits[0] ? CH_LF : CH_CR))
                    crlf_hits = crlf_hits + 3'd1;
                else
                    crlf_hits = (c == CH_CR) ? 3'd1 : 3'd0;
                if (crlf_hits >= 3'd4)
                begin
                    want = (num_neg || num_st == NUM_BLANKS) ? 16'd0 : len_value;
                    if (want != 16'd0 && want <= content_left)
                    begin
                        skip_left = content_left - want;
                        emit_left = want;
                        scan_st = SC_BODY;
                    end
                    else
                        scan_st = SC_DONE;
                end
            end
            SC_BODY:
            begin
                if (skip_left != 16'd0)
                    skip_left = skip_left - 16'd1;
                else if (emit_left == 16'd0)
                    scan_st = SC_DONE;
                else
                begin
                    beat.data = c;
                    beat.last = (emit_left == 16'd1);
                    body_expect_q.push_back(beat);
                    emit_left = emit_left - 16'd1;
                    if (emit_left == 16'd0)
                        scan_st = SC_DONE;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic deframe_byte(input logic [7:0] c);
        case (rec_phase)
            PH_CONTENT:
            begin
                if (content_left != 16'd0)
                begin
                    content_left = content_left - 16'd1;
                    if (rec_type == REC_STDOUT || rec_type == REC_STDERR)
                        scan_content_byte(c);
                end
                if (content_left == 16'd0)
                    rec_phase = (pad_left != 8'd0) ? PH_PADDING : PH_HEADER;
            end
            PH_PADDING:
            begin
                if (pad_left != 8'd0)
                    pad_left = pad_left - 8'd1;
                if (pad_left == 8'd0)
                    rec_phase = PH_HEADER;
            end
            default:
            begin
                rec_phase = PH_HEADER;
                case (hdr_idx)
                    HDR_TYPE:   rec_type = c;
                    HDR_LEN_HI: content_left[15:8] = c;
                    HDR_LEN_LO: content_left[7:0] = c;
                    HDR_PAD:    pad_left = c;
                    default:
                    begin
                    end
                endcase
                if (hdr_idx == HDR_LAST)
                begin
                    hdr_idx = 3'd0;
                    clear_scan();
                    if (content_left != 16'd0)
                        rec_phase = PH_CONTENT;
                    else if (pad_left != 8'd0)
                        rec_phase = PH_PADDING;
                end
                else
                    hdr_idx = hdr_idx + 3'd1;
            end
        endcase
    endtask

    // sender: one byte per item from stim_q, random gaps between items
    always @(posedge clk or negedge rst_n)
    begin : drive
        bit         accepted;
        bit         take_next;
        int         gap;
        stim_item_t item;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            in_byte      <= 8'd0;
            gap_left     <= 0;
            rec_phase    = PH_HEADER;
            hdr_idx      = 3'd0;
            rec_type     = 8'd0;
            content_left = 16'd0;
            pad_left     = 8'd0;
            clear_scan();
        end
        else
        begin
            accepted = in_valid && !in_stall;
            take_next = 1'b0;
            if (accepted)
            begin
                deframe_byte(in_byte);
                if ($urandom_range(0, 47) == 0)
                    tx_calm = !tx_calm;
                gap = idle_draw(tx_calm);
                if (gap == 0)
                    take_next = 1'b1;
                else
                    gap_left <= gap - 1;
            end
            else if (!in_valid)
            begin
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                else
                    take_next = 1'b1;
            end
            // a held item waits until every predicted body item has come out
            if (take_next && stim_q.size() != 0
                && !(stim_q[0].hold && body_expect_q.size() != 0))
            begin
                item = stim_q.pop_front();
                in_valid <= 1'b1;
                in_byte  <= item.data;
            end
            else if (accepted)
                in_valid <= 1'b0;
        end
    end

    // receiver: check each body item, then stall for a random count
    always @(posedge clk or negedge rst_n)
    begin : watch
        body_beat_t beat;
        int         n;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (body_expect_q.size() == 0)
            begin
                $display("%0t: unexpected body item: expected none, got byte %02h last %0b",
                         $time, body_byte, body_last);
                fail_count++;
            end
            else
            begin
                beat = body_expect_q.pop_front();
                if (body_byte !== beat.data)
                begin
                    $display("%0t: body_byte expected %02h got %02h",
                             $time, beat.data, body_byte);
                    fail_count++;
                end
                if (body_last !== beat.last)
                begin
                    $display("%0t: body_last expected %0b got %0b",
                             $time, beat.last, body_last);
                    fail_count++;
                end
            end
            if ($urandom_range(0, 31) == 0)
                rx_calm = !rx_calm;
            n = idle_draw(rx_calm);
            stall_left <= n;
            out_stall  <= (n != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left != 1);
        end
    end

    task automatic queue_byte(input logic [7:0] data, input bit hold);
        stim_item_t item;
        item.data = data;
        item.hold = hold;
        stim_q.push_back(item);
        bytes_queued++;
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            content_buf.push_back(s[i]);
    endtask

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++)
            content_buf.push_back(8'($urandom));
    endtask

    task automatic add_response(input string length_text, input int body_len);
        if ($urandom_range(0, 1) == 1)
            add_text("Status: 200 OK\r\n");
        add_text("Content-Length: ");
        add_text(length_text);
        add_text("\r\nContent-Type: text/plain\r\n\r\n");
        add_random(body_len);
    endtask

    // frames content_buf as one record and queues it with its padding
    task automatic send_record(input logic [7:0] rtype, input logic [7:0] pad,
                               input bit hold);
        logic [15:0] len;
        len = 16'(content_buf.size());
        queue_byte(8'($urandom), hold);
        queue_byte(rtype, 1'b0);
        queue_byte(8'($urandom), 1'b0);
        queue_byte(8'($urandom), 1'b0);
        queue_byte(len[15:8], 1'b0);
        queue_byte(len[7:0], 1'b0);
        queue_byte(pad, 1'b0);
        queue_byte(8'($urandom), 1'b0);
        foreach (content_buf[i])
            queue_byte(content_buf[i], 1'b0);
        for (int i = 0; i < pad; i++)
            queue_byte(8'($urandom), 1'b0);
        content_buf.delete();
    endtask

    initial
    begin : stimulus
        int         rec_no;
        int         bl;
        int         kind;
        string      val;
        logic [7:0] rtype;
        logic [7:0] pad;

        // directed records
        add_response("5", 5);
        send_record(REC_STDOUT, 8'd0, 1'b0);
        add_response("3", 7);
        send_record(REC_STDERR, 8'd3, 1'b1);
        add_response("0", 4);
        send_record(REC_STDOUT, 8'd1, 1'b0);
        add_response("-4", 6);
        send_record(REC_STDOUT, 8'd0, 1'b0);
        add_response("+2", 5);
        send_record(REC_STDERR, 8'd2, 1'b0);
        add_response("\t\v\f 4", 6);
        send_record(REC_STDOUT, 8'd0, 1'b0);
        add_response("99999", 8);
        send_record(REC_STDOUT, 8'd0, 1'b0);
        add_response("9", 8);
        send_record(REC_STDOUT, 8'd0, 1'b0);
        add_response("1", 1);
        send_record(REC_STDOUT, 8'd0, 1'b0);
        add_response("12abc", 14);
        send_record(REC_STDOUT, 8'd0, 1'b0);
        // blank line before any digit
        add_text("Content-Length: \r\n\r\n");
        add_random(4);
        send_record(REC_STDOUT, 8'd0, 1'b0);
        // other record types skip their content
        add_response("3", 5);
        send_record(8'd3, 8'd0, 1'b0);
        add_response("2", 5);
        send_record(8'hff, 8'd1, 1'b0);
        add_response("2", 5);
        send_record(8'h00, 8'd0, 1'b0);
        // empty content, with and without padding
        send_record(REC_STDOUT, 8'd0, 1'b0);
        send_record(REC_STDOUT, 8'd5, 1'b0);
        // nul bytes are ordinary, body holds the byte extremes
        content_buf.push_back(8'h00);
        add_text("Content-Length: 4\r\n\r\n");
        content_buf.push_back(8'h00);
        content_buf.push_back(8'hff);
        content_buf.push_back(8'h00);
        content_buf.push_back(8'hff);
        content_buf.push_back(8'haa);
        send_record(REC_STDOUT, 8'd0, 1'b0);
        // only the first key counts
        add_text("Content-Length: 2\r\nContent-Length: 4\r\n\r\n");
        add_random(5);
        send_record(REC_STDOUT, 8'd0, 1'b0);
        // repeated C restarts the key match
        add_text("CContent-Length: 3\r\n\r\n");
        add_random(4);
        send_record(REC_STDERR, 8'd0, 1'b0);
        // key split over two records does not match
        add_text("xContent-Len");
        send_record(REC_STDOUT, 8'd0, 1'b0);
        add_text("gth: 3\r\n\r\nabcd");
        send_record(REC_STDOUT, 8'd0, 1'b0);
        // long record, high length byte set, largest padding
        add_text("Content-Length: 270\r\n\r\n");
        add_random(280);
        send_record(REC_STDOUT, 8'd255, 1'b0);

        // random records, mostly well formed responses
        rec_no = 0;
        while (bytes_queued < TOTAL_BYTES)
        begin
            bl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 24);
            case ($urandom_range(0, 7))
                0, 1, 2: val = $sformatf("%0d", (bl == 0) ? 0 : $urandom_range(1, bl));
                3:       val = $sformatf("%0d", bl);
                4:       val = $sformatf("%0d", bl + 1);
                5:       val = $sformatf("-%0d", $urandom_range(0, 20));
                6:       val = $sformatf(" +%0d;q", $urandom_range(0, bl));
                default: val = ($urandom_range(0, 1) == 1) ? "0" : "70000";
            endcase
            rtype = ($urandom_range(0, 1) == 1) ? REC_STDOUT : REC_STDERR;
            pad = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 7));
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                if ($urandom_range(0, 3) == 0)
                    add_random($urandom_range(1, 6));
                add_response(val, bl);
            end
            else if (kind == 6)
            begin
                rtype = 8'($urandom);
                add_response(val, bl);
            end
            else if (kind == 7)
                add_random($urandom_range(0, 30));
            else if (kind == 8)
            begin
                add_text("Content-Lenght: 3\r\n\r\n");
                add_random(bl);
            end
            else
            begin
                // blank line broken off before the body
                add_text("Content-Length: ");
                add_text(val);
                add_text("\r\n\r");
                add_random(bl);
            end
            send_record(rtype, pad, rec_no == 0 || rec_no == 12);
            rec_no++;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (!(stim_q.size() == 0 && !in_valid && body_expect_q.size() == 0)
               && cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (cycle_count >= CYCLE_LIMIT)
            $display("%0t: timed out, %0d bytes unsent, %0d body items outstanding",
                     $time, stim_q.size(), body_expect_q.size());
        else if (body_expect_q.size() != 0)
            $display("%0t: %0d body items never arrived", $time, body_expect_q.size());

        if (cycle_count < CYCLE_LIMIT && fail_count == 0 && body_expect_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
